/* hdl/mcst_pkg.sv */
// Shared types and constants of the multi-channel software timer.
`default_nettype none
package mcst_pkg;

	localparam int unsigned PADDR_W = 3;

	localparam logic [2:0] KIND_CREATE = 3'd0;
	localparam logic [2:0] KIND_START  = 3'd1;
	localparam logic [2:0] KIND_STOP   = 3'd2;
	localparam logic [2:0] KIND_DELETE = 3'd3;
	localparam logic [2:0] KIND_TICK   = 3'd4;
	localparam logic [2:0] KIND_TIME   = 3'd5;

	localparam logic [15:0] TICK_STEP_RESET = 16'd10;
	localparam logic        REG_TICK_STEP   = 1'b0;

	typedef enum logic [1:0] {
		CH_UNUSED    = 2'd0,
		CH_STOPPED   = 2'd1,
		CH_RUNNING   = 2'd2,
		CH_COMPLETED = 2'd3
	} chan_state_t;

	typedef struct packed {
		logic [31:0] expiry;
		logic [31:0] period;
		logic        mode;
		chan_state_t st;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{expiry: 32'd0, period: 32'd0, mode: 1'b0, st: CH_UNUSED};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OP,
		ST_SCAN,
		ST_FIN
	} fsm_t;

	// result payload handed to the output register
	typedef struct packed {
		logic       ok;
		logic       fired;
		logic [2:0] fired_id;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

/* hdl/mcst_mem.sv */
// Channel table memory: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module mcst_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            rd_en,
	input  wire logic [AW-1:0]   rd_addr,
	output mcst_pkg::entry_t     rd_data,
	input  wire logic            wr_en,
	input  wire logic [AW-1:0]   wr_addr,
	input  mcst_pkg::entry_t     wr_data
);
	import mcst_pkg::*;

	entry_t           mem [DEPTH];
	entry_t           rdata_q;
	logic [DEPTH-1:0] vld_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written entries read as their reset value
	assign rd_data = rvld_q ? rdata_q : ENTRY_RESET;

endmodule
`default_nettype wire

/* hdl/mcst_cfg.sv */
// APB register block holding the tick step.
`default_nettype none
module mcst_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mcst_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output logic      [15:0]                 tick_step
);
	import mcst_pkg::*;

	logic [15:0] tick_step_q;
	logic        sel_step;

	assign sel_step = (paddr[PADDR_W-1] == REG_TICK_STEP) && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= TICK_STEP_RESET;
		end else if (psel && penable && pwrite && sel_step) begin
			tick_step_q <= pwdata[15:0];
		end
	end

	assign pready    = 1'b1;
	assign prdata    = sel_step ? {16'd0, tick_step_q} : 32'd0;
	assign tick_step = tick_step_q;

endmodule
`default_nettype wire

/* hdl/mcst_ctrl.sv */
// Sequencer: read-modify-write of channel entries, tick scan and output register.
`default_nettype none
module mcst_ctrl #(
	parameter int CHANNELS = 8,
	parameter int AW       = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [2:0]    kind,
	input  wire logic [2:0]    timer_id,
	input  wire logic [31:0]   period,
	input  wire logic          periodic,
	input  wire logic [15:0]   tick_step,
	output logic               rd_en,
	output logic [AW-1:0]      rd_addr,
	input  mcst_pkg::entry_t   rd_data,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output mcst_pkg::entry_t   wr_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               ok,
	output logic               fired,
	output logic [2:0]         fired_id,
	output logic [31:0]        time_now,
	output logic               last
);
	import mcst_pkg::*;

	localparam logic [6:0]    CH_N     = 7'(CHANNELS);
	localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

	fsm_t          state_q, state_d;
	logic [2:0]    kind_q;
	logic [2:0]    id_q;
	logic [31:0]   per_q;
	logic          mode_q;
	logic [31:0]   time_q;
	logic [AW-1:0] idx_q;
	logic          pend_q;
	logic [2:0]    pend_id_q;
	logic          out_valid_q;
	res_t          res_q;
	logic [31:0]   time_out_q;

	logic          acc;
	logic          slot_free;
	logic          in_id_ok;
	logic          id_ok;
	logic [31:0]   diff;
	logic          hit;
	logic          adv;
	logic          op_ok;
	logic          op_wr;
	entry_t        op_data;
	entry_t        scan_data;
	logic          emit;
	res_t          res_c;

	assign in_stall  = (state_q != ST_IDLE);
	assign acc       = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign in_id_ok  = {4'd0, timer_id} < CH_N;
	assign id_ok     = {4'd0, id_q} < CH_N;

	// wrap-aware expiry: reached when time - expiry lies in the lower half
	assign diff = time_q - rd_data.expiry;
	assign hit  = (rd_data.st == CH_RUNNING) && !diff[31];
	assign adv  = !(hit && pend_q && !slot_free);

	// single-channel operations
	always_comb begin
		op_ok   = 1'b0;
		op_wr   = 1'b0;
		op_data = rd_data;
		unique case (kind_q)
			KIND_CREATE: begin
				if (id_ok) begin
					op_ok   = 1'b1;
					op_wr   = 1'b1;
					op_data = '{expiry: 32'd0, period: per_q, mode: mode_q, st: CH_STOPPED};
				end
			end
			KIND_START: begin
				if (id_ok && rd_data.st != CH_UNUSED) begin
					op_ok          = 1'b1;
					op_wr          = 1'b1;
					op_data.st     = CH_RUNNING;
					op_data.expiry = time_q + rd_data.period;
				end
			end
			KIND_STOP: begin
				if (id_ok && rd_data.st == CH_RUNNING) begin
					op_ok      = 1'b1;
					op_wr      = 1'b1;
					op_data.st = CH_STOPPED;
				end
			end
			KIND_DELETE: begin
				if (id_ok) begin
					op_ok          = 1'b1;
					op_wr          = 1'b1;
					op_data.st     = CH_UNUSED;
					op_data.expiry = 32'd0;
					op_data.mode   = 1'b0;
				end
			end
			KIND_TIME: begin
				op_ok = 1'b1;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		scan_data = rd_data;
		if (rd_data.mode) begin
			scan_data.expiry = time_q + rd_data.period;
		end else begin
			scan_data.st = CH_COMPLETED;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = (kind == KIND_TICK) ? ST_SCAN : ST_OP;
				end
			end
			ST_OP: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (adv && idx_q == LAST_IDX) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory access and result selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = op_data;
		emit    = 1'b0;
		res_c   = '{ok: 1'b1, fired: 1'b0, fired_id: 3'd0, last: 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				rd_en = acc;
				if (kind != KIND_TICK && in_id_ok) begin
					rd_addr = AW'(timer_id);
				end
			end
			ST_OP: begin
				if (slot_free) begin
					emit     = 1'b1;
					res_c.ok = op_ok;
					wr_en    = op_wr;
					wr_addr  = AW'(id_q);
				end
			end
			ST_SCAN: begin
				if (adv) begin
					wr_en   = hit;
					wr_addr = idx_q;
					wr_data = scan_data;
					if (hit && pend_q) begin
						// an earlier hit goes out now that a later one exists
						emit  = 1'b1;
						res_c = '{ok: 1'b1, fired: 1'b1, fired_id: pend_id_q, last: 1'b0};
					end
					if (idx_q != LAST_IDX) begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
					end
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					emit = 1'b1;
					if (pend_q) begin
						res_c = '{ok: 1'b1, fired: 1'b1, fired_id: pend_id_q, last: 1'b1};
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			time_q      <= 32'd0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && kind == KIND_TICK) begin
				time_q <= time_q + {16'd0, tick_step};
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else if (state_q == ST_SCAN && adv) begin
				if (idx_q != LAST_IDX) begin
					idx_q <= idx_q + AW'(1);
				end
				if (hit) begin
					pend_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= kind;
			id_q   <= timer_id;
			per_q  <= period;
			mode_q <= periodic;
		end
		if (state_q == ST_SCAN && adv && hit) begin
			pend_id_q <= 3'(idx_q);
		end
		if (emit) begin
			res_q      <= res_c;
			time_out_q <= time_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = res_q.ok;
	assign fired     = res_q.fired;
	assign fired_id  = res_q.fired_id;
	assign last      = res_q.last;
	assign time_now  = time_out_q;

endmodule
`default_nettype wire

/* hdl/multi_channel_software_timer.sv */
// Top level of the multi-channel software timer.
// Input channel (in_valid/in_stall) takes one item: kind, timer_id, period, periodic.
// Output channel (out_valid/out_stall) returns results: ok, fired, fired_id, time_now, last;
// last marks the final result of an item.
// Create, start, stop, delete and read-time give one result: a table read,
// then write-back with the result register loaded.
// A tick scans every channel, one table entry per cycle while the scan is not paused,
// giving one result per expired channel in id order, or one result if none expired.
// One item is in flight at a time; in_stall is high from acceptance until the
// item's last result is loaded into the output register.
// A stalled receiver holds the output register; the scan pauses when a further
// result is ready and the register is still occupied.
// Reset clears the time counter, the output valid flag and the table's valid bits;
// unwritten channels read as unused with zero expiry, period and mode.
// tick_step sits at APB address 0 and resets to 10.
`default_nettype none
module multi_channel_software_timer #(
	parameter int CHANNELS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [2:0]                   kind,
	input  wire logic [2:0]                   timer_id,
	input  wire logic [31:0]                  period,
	input  wire logic                         periodic,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              ok,
	output logic                              fired,
	output logic [2:0]                        fired_id,
	output logic [31:0]                       time_now,
	output logic                              last,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mcst_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);
	import mcst_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [15:0]   tick_step;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	mcst_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tick_step (tick_step)
	);

	mcst_mem #(
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	mcst_ctrl #(
		.CHANNELS (CHANNELS),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.timer_id  (timer_id),
		.period    (period),
		.periodic  (periodic),
		.tick_step (tick_step),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ok        (ok),
		.fired     (fired),
		.fired_id  (fired_id),
		.time_now  (time_now),
		.last      (last)
	);

endmodule
`default_nettype wire

/* hdl/mcst_chk.sv */
// Port-level checker for the software timer, bound to the top level.
`default_nettype none
module mcst_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        ok,
	input wire logic        fired,
	input wire logic [2:0]  fired_id,
	input wire logic [31:0] time_now,
	input wire logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fired) && $stable(fired_id)
			&& $stable(time_now) && $stable(last) && $stable(ok))
		else $error("stalled result changed");

	// reset held from power-up may only take effect at the first clock edge
	a_rst: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fired |-> ok)
		else $error("expired-channel result without ok");

	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fired |-> last && fired_id == 3'd0)
		else $error("non-firing result not final or carries an id");

endmodule

bind multi_channel_software_timer mcst_chk u_chk (.*);
`default_nettype wire
